FILE: design/rgba_to_mono_bitplane_packer_core_assert.svh
// Assertion macros used by the packer core RTL.
`ifndef RGBA_TO_MONO_BITPLANE_PACKER_CORE_ASSERT_SVH
`define RGBA_TO_MONO_BITPLANE_PACKER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RTMBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rtmbp assertion failed");

// Next-cycle implication, checked outside reset.
`define RTMBP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rtmbp assertion failed");

`endif

FILE: design/rtmbp_pkg.sv
package rtmbp_pkg;

	localparam int SAMPLE_W = 8;
	localparam int WORD_W   = 16;
	localparam int CFG_W    = 13;
	localparam int CHAN_W   = 3;
	localparam int REG_IDX_W = 2;

	// register indexes on the config port
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	// channel count codes
	localparam logic [CHAN_W-1:0] CH_NONE       = 3'd0;
	localparam logic [CHAN_W-1:0] CH_GRAY       = 3'd1;
	localparam logic [CHAN_W-1:0] CH_GRAY_ALPHA = 3'd2;
	localparam logic [CHAN_W-1:0] CH_RGB        = 3'd3;

	localparam logic [SAMPLE_W-1:0] ALPHA_CLEAR  = 8'd32;
	localparam logic [SAMPLE_W-1:0] ALPHA_OPAQUE = 8'd224;
	localparam logic [SAMPLE_W-1:0] INK_LEVEL    = 8'd224;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 8'd255;
	localparam logic [WORD_W-1:0]   WORD_MSB     = 16'h8000;

	localparam logic [CFG_W-1:0]  RST_WIDTH    = 13'd16;
	localparam logic [CFG_W-1:0]  RST_HEIGHT   = 13'd16;
	localparam logic [CHAN_W-1:0] RST_CHANNELS = 3'd4;

	typedef struct packed {
		logic [SAMPLE_W-1:0] s3;
		logic [SAMPLE_W-1:0] s2;
		logic [SAMPLE_W-1:0] s1;
		logic [SAMPLE_W-1:0] s0;
	} pixel_t;

	typedef struct packed {
		logic visible;
		logic ink;
	} pix_class_t;

	typedef struct packed {
		logic [CFG_W-1:0] width;
		logic [CFG_W-1:0] height;
	} dims_t;

endpackage

FILE: design/rgba_to_mono_bitplane_packer_core.sv
// Channel  | Role   | Payload (low bit first)
// s_axis   | in     | tdata: sample_0, sample_1, sample_2, sample_3 (8 b each)
// m_axis   | out    | tdata: mask_word[15:0], data_word[31:16];
//          |        | tuser: row_end[0], image_end[1]
// cfg      | in     | cfg_index selects register, cfg_data carries value
//
// One pixel is taken per cycle unless a pixel that closes a word waits on
// a stalled output; such a pixel goes from the input register, loaded at
// the transfer, through classify and pack into the result register.
// arst_n clears counters, accumulators and valid flags; registers return
// to width 16, height 16, four channels.
// A stalled output only holds back a pixel that closes a word; other
// pixels keep flowing into the accumulators.
`include "rgba_to_mono_bitplane_packer_core_assert.svh"

module rgba_to_mono_bitplane_packer_core #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// pixel input
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [31:0]                     s_axis_tdata,  // sample_0..sample_3
	// word pair output
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [31:0]                     m_axis_tdata,  // mask_word, data_word
	output logic [1:0]                      m_axis_tuser,  // row_end, image_end
	// register writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rtmbp_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [rtmbp_pkg::CFG_W-1:0]     cfg_data
);
	import rtmbp_pkg::*;

	dims_t             dims_q;
	logic [CHAN_W-1:0] channels_q;

	pixel_t            pix_s1;
	logic              valid_s1;
	logic              pack_ready;
	pix_class_t        cls;

	logic [WORD_W-1:0] mask_w, data_w;
	logic              row_end, image_end;

	// config: always ready, writes past the register list are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q.width  <= RST_WIDTH;
			dims_q.height <= RST_HEIGHT;
			channels_q    <= RST_CHANNELS;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:   dims_q.width  <= cfg_data;
				REG_IMAGE_HEIGHT:  dims_q.height <= cfg_data;
				REG_CHANNEL_COUNT: channels_q    <= cfg_data[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// input register: refills in the same cycle it drains
	assign s_axis_tready = !valid_s1 || pack_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			pix_s1 <= pixel_t'(s_axis_tdata);
		end
	end

	rtmbp_classify u_classify (
		.pix      (pix_s1),
		.channels (channels_q),
		.cls      (cls)
	);

	rtmbp_pack #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pack (
		.clk           (clk),
		.arst_n        (arst_n),
		.dims          (dims_q),
		.in_valid      (valid_s1),
		.in_ready      (pack_ready),
		.cls           (cls),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_mask      (mask_w),
		.out_data      (data_w),
		.out_row_end   (row_end),
		.out_image_end (image_end)
	);

	assign m_axis_tdata = {data_w, mask_w};
	assign m_axis_tuser = {image_end, row_end};

	// a transfer in always lands in the input register
	`RTMBP_ASSERT_NXT(a_in_lands, clk, arst_n, s_axis_tvalid && s_axis_tready, valid_s1)
	// ink bits only where the pixel is visible
	`RTMBP_ASSERT_IMP(a_ink_visible, clk, arst_n, m_axis_tvalid, (data_w & ~mask_w) == '0)
	// image end only on a word pair that closes a row
	`RTMBP_ASSERT_IMP(a_image_row, clk, arst_n, m_axis_tvalid && image_end, row_end)

endmodule

FILE: design/rtmbp_classify.sv
module rtmbp_classify (
	input  rtmbp_pkg::pixel_t            pix,
	input  logic [rtmbp_pkg::CHAN_W-1:0] channels,
	output rtmbp_pkg::pix_class_t        cls
);
	import rtmbp_pkg::*;

	logic [SAMPLE_W-1:0] r, g, b, a, mn_rg, mn;
	logic                opaque, all_black, all_white;

	always_comb begin
		case (channels) inside
			CH_NONE, CH_GRAY: begin
				r = pix.s0; g = pix.s0; b = pix.s0; a = SAMPLE_MAX;
			end
			CH_GRAY_ALPHA: begin
				r = pix.s0; g = pix.s0; b = pix.s0; a = pix.s1;
			end
			CH_RGB: begin
				r = pix.s0; g = pix.s1; b = pix.s2; a = SAMPLE_MAX;
			end
			default: begin
				r = pix.s0; g = pix.s1; b = pix.s2; a = pix.s3;
			end
		endcase
	end

	assign mn_rg     = (g < r) ? g : r;
	assign mn        = (b < mn_rg) ? b : mn_rg;
	assign opaque    = (a >= ALPHA_OPAQUE);
	assign all_black = (r == '0) && (g == '0) && (b == '0);
	assign all_white = (r == SAMPLE_MAX) && (g == SAMPLE_MAX) && (b == SAMPLE_MAX);

	always_comb begin
		if (a < ALPHA_CLEAR) begin
			cls.visible = 1'b0;
			cls.ink     = 1'b0;
		end else if (opaque && all_black) begin
			cls.visible = 1'b1;
			cls.ink     = 1'b1;
		end else if (opaque && all_white) begin
			cls.visible = 1'b1;
			cls.ink     = 1'b0;
		end else begin
			cls.visible = 1'b1;
			cls.ink     = (mn < INK_LEVEL);
		end
	end

endmodule

FILE: design/rtmbp_pack.sv
module rtmbp_pack #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rtmbp_pkg::dims_t             dims,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  rtmbp_pkg::pix_class_t        cls,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rtmbp_pkg::WORD_W-1:0] out_mask,
	output logic [rtmbp_pkg::WORD_W-1:0] out_data,
	output logic                         out_row_end,
	output logic                         out_image_end
);
	import rtmbp_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CMP_WA = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int CMP_W  = ((CMP_WA > CFG_W) ? CMP_WA : CFG_W) + 1;
	localparam int POS_W  = $clog2(WORD_W);

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [WORD_W-1:0] mask_q, data_q;
	logic [WORD_W-1:0] bit_sel, mask_nxt, data_nxt;
	logic [CMP_W-1:0]  w_raw, h_raw, w_eff, h_eff;
	logic              last_col, last_row, full, emit, advance;

	// dimension clamp: zero reads as one, oversize saturates
	assign w_raw = CMP_W'(dims.width);
	assign h_raw = CMP_W'(dims.height);
	assign w_eff = (w_raw == '0) ? CMP_W'(1) :
	               (w_raw > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : w_raw;
	assign h_eff = (h_raw == '0) ? CMP_W'(1) :
	               (h_raw > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT) : h_raw;

	assign last_col = CMP_W'(col_q) >= (w_eff - CMP_W'(1));
	assign last_row = CMP_W'(row_q) >= (h_eff - CMP_W'(1));
	assign full     = (col_q[POS_W-1:0] == {POS_W{1'b1}});
	assign emit     = last_col || full;

	assign bit_sel  = WORD_MSB >> col_q[POS_W-1:0];
	assign mask_nxt = cls.visible ? (mask_q | bit_sel) : mask_q;
	assign data_nxt = cls.ink ? (data_q | bit_sel) : data_q;

	// a pixel that closes no word moves on even while the output stalls
	assign in_ready = !emit || !out_valid || out_ready;
	assign advance  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			mask_q    <= '0;
			data_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (advance && emit) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (advance) begin
				if (emit) begin
					mask_q <= '0;
					data_q <= '0;
					if (last_col) begin
						col_q <= '0;
						row_q <= last_row ? '0 : row_q + ROW_W'(1);
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end else begin
					mask_q <= mask_nxt;
					data_q <= data_nxt;
					col_q  <= col_q + COL_W'(1);
				end
			end
		end
	end

	// result payload, loaded only on an emitting pixel
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_mask      <= mask_nxt;
			out_data      <= data_nxt;
			out_row_end   <= last_col;
			out_image_end <= last_col && last_row;
		end
	end

endmodule
